[src/lmks_pkg.sv]
// ----------------------------------------------------------------------------
// lmks_pkg
// Shared types, codes and the character table of the layered keypad scanner.
// ----------------------------------------------------------------------------
package lmks_pkg;

  localparam int unsigned ROWS     = 4;
  localparam int unsigned COLS     = 4;
  localparam int unsigned LAYERS   = 3;
  localparam int unsigned DEB_W    = 16;

  typedef logic [COLS-1:0]  col_t;
  typedef logic [ROWS-1:0]  row_drv_t;
  typedef logic [1:0]       row_idx_t;
  typedef logic [1:0]       layer_t;
  typedef logic [7:0]       char_t;
  typedef logic [DEB_W-1:0] deb_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CHAR   = 3'd1,
    EV_LAYER  = 3'd2,
    EV_DELETE = 3'd3,
    EV_SUBMIT = 3'd4,
    EV_TERM   = 3'd5
  } event_kind_t;

  localparam col_t     COLS_IDLE = 4'h0F;
  localparam row_drv_t ROW_ALL   = 4'h0;
  localparam deb_t     DEB_RESET = 16'd20;

  localparam char_t CH_LAYER  = 8'h23; // '#'
  localparam char_t CH_TERM   = 8'h3B; // ';'
  localparam char_t CH_DELETE = 8'h26; // '&'
  localparam char_t CH_SUBMIT = 8'h3D; // '='

  // index is {layer, row}, entry is the column
  localparam logic [0:LAYERS*ROWS-1][0:COLS-1][7:0] KEY_TABLE = '{
    '{"0", "1", "2", "3"}, '{"4", "5", "6", "7"},
    '{"8", "9", "@", "~"}, '{" ", "&", "=", "#"},
    '{"a", "b", "c", "d"}, '{"e", "f", "g", "h"},
    '{"i", "j", "n", "k"}, '{"l", "m", "=", "#"},
    '{"o", "p", "q", "r"}, '{"s", "t", "u", "v"},
    '{"w", "x", "y", "z"}, '{":", ";", "=", "#"}
  };

  typedef struct packed {
    logic     hit;
    row_idx_t col;
  } col_hit_t;

  function automatic row_drv_t row_pattern(input row_idx_t row);
    row_pattern = ~(row_drv_t'(1) << row);
  endfunction

  // exactly one low column decodes, anything else misses
  function automatic col_hit_t column_of(input col_t cols);
    col_hit_t r;
    r = '{hit: 1'b0, col: 2'd0};
    case (cols)
      4'h0E: r = '{hit: 1'b1, col: 2'd0};
      4'h0D: r = '{hit: 1'b1, col: 2'd1};
      4'h0B: r = '{hit: 1'b1, col: 2'd2};
      4'h07: r = '{hit: 1'b1, col: 2'd3};
      default: r = '{hit: 1'b0, col: 2'd0};
    endcase
    return r;
  endfunction

endpackage

[src/layered_matrix_keypad_scanner.sv]
// ----------------------------------------------------------------------------
// layered_matrix_keypad_scanner
// 4x4 keypad scan state machine with debounce and three character layers.
// ----------------------------------------------------------------------------
// an accepted item passes the input register and then the output register
// throughput: one item per cycle while out_stall does not hold the output, set by the scan state update
// an input register and an output register part the two channels
// reset (rst, synchronous): wait for release, layer 0, last key 0,
// debounce_ticks 20, both stages empty
module layered_matrix_keypad_scanner (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lmks_pkg::deb_t         cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lmks_pkg::col_t         col_pins,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lmks_pkg::row_drv_t     row_drive,
  output logic [2:0]             event_kind,
  output lmks_pkg::char_t        key_code,
  output lmks_pkg::layer_t       layer_now
);
  import lmks_pkg::*;

  typedef enum logic [1:0] {
    PH_RELEASE  = 2'd0,
    PH_PRESS    = 2'd1,
    PH_DEBOUNCE = 2'd2,
    PH_SCAN     = 2'd3
  } phase_t;

  deb_t     debounce_ticks;
  phase_t   scan_phase, scan_phase_next;
  row_idx_t row_index, row_index_next;
  deb_t     debounce_count, debounce_count_next;
  layer_t   key_layer, key_layer_next;
  char_t    last_key, last_key_next;

  logic     in_v;
  col_t     cols;
  logic     advance;

  row_drv_t    drive_next;
  event_kind_t kind_next;
  char_t       code_next;

  deb_t     limit;
  deb_t     count_inc;
  layer_t   lay;
  row_idx_t row_inc;
  col_hit_t hit;
  char_t    key;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_v && !advance;

  always_comb begin
    scan_phase_next     = scan_phase;
    row_index_next      = row_index;
    debounce_count_next = debounce_count;
    key_layer_next      = key_layer;
    last_key_next       = last_key;
    drive_next          = ROW_ALL;
    kind_next           = EV_NONE;
    code_next           = '0;
    limit     = (debounce_ticks == '0) ? deb_t'(1) : debounce_ticks;
    count_inc = debounce_count + deb_t'(1);
    lay       = (key_layer == 2'd3) ? 2'd0 : key_layer;
    row_inc   = row_index + 2'd1;
    hit       = column_of(cols);
    key       = hit.hit ? KEY_TABLE[{lay, row_index}][hit.col] : last_key;
    case (scan_phase)
      PH_RELEASE: begin
        if (cols == COLS_IDLE) scan_phase_next = PH_PRESS;
      end
      PH_PRESS: begin
        if (cols != COLS_IDLE) begin
          debounce_count_next = '0;
          scan_phase_next     = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        debounce_count_next = count_inc;
        if (count_inc >= limit) begin
          if (cols != COLS_IDLE) begin
            row_index_next  = 2'd0;
            scan_phase_next = PH_SCAN;
            drive_next      = row_pattern(2'd0);
          end else begin
            scan_phase_next = PH_PRESS;
          end
        end
      end
      PH_SCAN: begin
        if (cols == COLS_IDLE) begin
          row_index_next = row_inc;
          drive_next     = row_pattern(row_inc);
        end else begin
          // a non one-hot pattern reports the previous key again
          last_key_next   = key;
          code_next       = key;
          scan_phase_next = PH_RELEASE;
          if (key == CH_LAYER) begin
            kind_next      = EV_LAYER;
            key_layer_next = (lay == 2'd2) ? 2'd0 : lay + 2'd1;
          end else if (key == CH_TERM) begin
            kind_next = EV_TERM;
          end else if (key == CH_DELETE) begin
            kind_next = EV_DELETE;
          end else if (key == CH_SUBMIT) begin
            kind_next = EV_SUBMIT;
          end else begin
            kind_next = EV_CHAR;
          end
        end
      end
      default: scan_phase_next = PH_RELEASE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEB_RESET;
      scan_phase     <= PH_RELEASE;
      row_index      <= '0;
      debounce_count <= '0;
      key_layer      <= '0;
      last_key       <= '0;
      in_v           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) debounce_ticks <= cfg_data;
      if (!in_stall) begin
        in_v <= in_valid;
        if (in_valid) cols <= col_pins;
      end
      if (advance) begin
        out_valid <= in_v;
        if (in_v) begin
          scan_phase     <= scan_phase_next;
          row_index      <= row_index_next;
          debounce_count <= debounce_count_next;
          key_layer      <= key_layer_next;
          last_key       <= last_key_next;
          row_drive      <= drive_next;
          event_kind     <= kind_next;
          key_code       <= code_next;
          layer_now      <= key_layer_next;
        end
      end
    end
  end

  a_event_rows_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_NONE |-> row_drive == ROW_ALL)
    else $error("event reported while a row is still selected");

  a_no_event_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_NONE |-> key_code == '0)
    else $error("key code set without an event");

  a_layer_range: assert property (@(posedge clk) disable iff (rst)
    key_layer != 2'd3)
    else $error("key layer out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_v && out_valid && out_stall)
    else $error("input stalled while the pipeline can move");

  a_scan_drives_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_NONE && scan_phase == PH_SCAN
    |-> row_drive == row_pattern(row_index))
    else $error("scan row drive does not match row index");

endmodule

[tb/layered_matrix_keypad_scanner_tb.sv]
// ----------------------------------------------------------------------------
// layered_matrix_keypad_scanner_tb
// Drives pin samples from a simulated 4x4 keypad that answers the predicted
// row drive, predicts every result from the scan state machine and checks
// the block's results against that prediction.
// ----------------------------------------------------------------------------
module layered_matrix_keypad_scanner_tb;
  import lmks_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    PH_WAIT_RELEASE,
    PH_WAIT_PRESS,
    PH_DEBOUNCE,
    PH_SCAN
  } scan_phase_t;

  typedef struct packed {
    row_drv_t    drive;
    event_kind_t kind;
    char_t       code;
    layer_t      layer;
  } scan_result_t;

  class keypad_scoreboard;
    scan_result_t pending_scans[$];
    deb_t         deb_ticks;
    scan_phase_t  phase;
    row_idx_t     row_idx;
    deb_t         deb_count;
    layer_t       layer;
    char_t        last_key;
    row_drv_t     next_drive;
    event_kind_t  last_kind;
    int           errors;

    function new();
      deb_ticks  = DEB_RESET;
      phase      = PH_WAIT_RELEASE;
      row_idx    = '0;
      deb_count  = '0;
      layer      = '0;
      last_key   = '0;
      next_drive = ROW_ALL;
      last_kind  = EV_NONE;
      errors     = 0;
    endfunction

    function int deb_limit();
      return (deb_ticks == 0) ? 1 : int'(deb_ticks);
    endfunction

    function char_t key_glyph(int idx, int col);
      string s;
      case (idx)
        0:  s = "0123";
        1:  s = "4567";
        2:  s = "89@~";
        3:  s = " &=#";
        4:  s = "abcd";
        5:  s = "efgh";
        6:  s = "ijnk";
        7:  s = "lm=#";
        8:  s = "opqr";
        9:  s = "stuv";
        10: s = "wxyz";
        default: s = ":;=#";
      endcase
      return char_t'(s[col]);
    endfunction

    function void note_sample(col_t cols);
      scan_result_t r;
      int           col;
      int           lay;
      r.drive = ROW_ALL;
      r.kind  = EV_NONE;
      r.code  = '0;
      col     = -1;
      case (phase)
        PH_WAIT_RELEASE: begin
          if (cols == COLS_IDLE) phase = PH_WAIT_PRESS;
        end
        PH_WAIT_PRESS: begin
          if (cols != COLS_IDLE) begin
            deb_count = '0;
            phase     = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          deb_count = deb_count + 1'b1;
          if (int'(deb_count) >= deb_limit()) begin
            if (cols != COLS_IDLE) begin
              row_idx = '0;
              phase   = PH_SCAN;
              r.drive = 4'b1110;
            end else begin
              phase = PH_WAIT_PRESS;
            end
          end
        end
        default: begin
          if (cols == COLS_IDLE) begin
            row_idx = row_idx + 1'b1;
            r.drive = 4'hF ^ (4'h1 << row_idx);
          end else begin
            lay = int'(layer) % 3;
            case (cols)
              4'b1110: col = 0;
              4'b1101: col = 1;
              4'b1011: col = 2;
              4'b0111: col = 3;
              default: col = -1;
            endcase
            // a pattern that is not one-hot reports the previous key again
            if (col >= 0) last_key = key_glyph(lay * 4 + int'(row_idx), col);
            r.code = last_key;
            if (last_key == CH_LAYER) begin
              r.kind = EV_LAYER;
              layer  = layer_t'((lay + 1) % 3);
            end else if (last_key == CH_TERM) begin
              r.kind = EV_TERM;
            end else if (last_key == CH_DELETE) begin
              r.kind = EV_DELETE;
            end else if (last_key == CH_SUBMIT) begin
              r.kind = EV_SUBMIT;
            end else begin
              r.kind = EV_CHAR;
            end
            phase = PH_WAIT_RELEASE;
          end
        end
      endcase
      r.layer    = layer;
      next_drive = r.drive;
      last_kind  = r.kind;
      pending_scans.push_back(r);
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(row_drv_t drive, logic [2:0] kind, char_t code,
                               layer_t lay);
      scan_result_t e;
      if (pending_scans.size() == 0) begin
        $display("%0t: result with nothing expected, actual drive=%h kind=%0d code=%0d layer=%0d",
                 $time, drive, kind, code, lay);
        errors++;
        return;
      end
      e = pending_scans.pop_front();
      field_check("row_drive", int'(e.drive), int'(drive));
      field_check("event_kind", int'(e.kind), int'(kind));
      field_check("key_code", int'(e.code), int'(code));
      field_check("layer_now", int'(e.layer), int'(lay));
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  deb_t        cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  col_t        col_pins  = COLS_IDLE;
  logic        out_valid;
  logic        out_stall = 1'b0;
  row_drv_t    row_drive;
  logic [2:0]  event_kind;
  char_t       key_code;
  layer_t      layer_now;

  keypad_scoreboard sb;
  bit gaps_on      = 1'b1;
  int stall_left   = 0;
  int samples_sent = 0;
  int cycle_count  = 0;

  layered_matrix_keypad_scanner DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .col_pins   (col_pins),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_drive  (row_drive),
    .event_kind (event_kind),
    .key_code   (key_code),
    .layer_now  (layer_now)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // handshake signals settle by the falling edge, so sample there
  always begin : result_monitor
    logic       took;
    row_drv_t   d;
    logic [2:0] k;
    char_t      c;
    layer_t     l;
    @(negedge clk);
    took = out_valid && !out_stall && !rst;
    d    = row_drive;
    k    = event_kind;
    c    = key_code;
    l    = layer_now;
    @(posedge clk);
    if (took) sb.check_result(d, k, c, l);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_sample(input col_t cols);
    logic stalled;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    col_pins <= cols;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sb.note_sample(cols);
    samples_sent++;
  endtask

  task automatic set_debounce(input deb_t ticks);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid    <= 1'b0;
    sb.deb_ticks  = ticks;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (sb.pending_scans.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // keys pressed on the pad, bit row*4+col; a key reads only while its row is low
  function automatic col_t pad_sample(logic [15:0] keys, row_drv_t drive);
    col_t s;
    s = COLS_IDLE;
    for (int r = 0; r < 4; r++)
      if (!drive[r])
        for (int c = 0; c < 4; c++)
          if (keys[r * 4 + c]) s[c] = 1'b0;
    return s;
  endfunction

  task automatic press_keys(input logic [15:0] keys, input bit bounce, input bit lift);
    int n;
    int cap;
    bit lifted;
    n      = 0;
    lifted = 1'b0;
    repeat ($urandom_range(1, 3)) send_sample(COLS_IDLE);
    cap = sb.deb_limit() + 16;
    do begin
      if (lift && !lifted && sb.phase == PH_SCAN) begin
        // keys let go mid-scan, rows keep cycling
        repeat ($urandom_range(1, 6)) send_sample(COLS_IDLE);
        lifted = 1'b1;
      end else if (bounce && sb.phase == PH_DEBOUNCE && $urandom_range(0, 7) == 0) begin
        send_sample(COLS_IDLE);
      end else begin
        send_sample(pad_sample(keys, sb.next_drive));
      end
      n++;
    end while (sb.last_kind == EV_NONE && n < cap);
  endtask

  function automatic logic [15:0] random_key();
    int r;
    r = ($urandom_range(0, 2) == 0) ? 3 : $urandom_range(0, 3);
    return 16'h1 << (r * 4 + $urandom_range(0, 3));
  endfunction

  task automatic run_random(input int count);
    int start;
    int pick;
    start = samples_sent;
    while (samples_sent - start < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        repeat ($urandom_range(1, 5)) send_sample(col_t'($urandom_range(0, 15)));
      end else if (pick < 4) begin
        press_keys(random_key() | random_key() | (pick == 3 ? random_key() : 16'h0),
                   1'($urandom_range(0, 1)), 1'b0);
      end else if (pick == 4) begin
        press_keys(random_key(), 1'b0, 1'b1);
      end else begin
        press_keys(random_key(), 1'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero debounce behaves as one tick
    set_debounce(16'd0);
    press_keys(16'h0003, 1'b0, 1'b0);  // two columns before any key: code zero
    press_keys(16'h8000, 1'b0, 1'b0);  // layer switch
    press_keys(16'h3000, 1'b0, 1'b0);  // two columns keep the switch key
    press_keys(16'h2000, 1'b0, 1'b0);  // terminate on the last layer
    press_keys(16'h0400, 1'b0, 1'b1);  // release during the scan

    for (int p = 0; p < 6; p++) begin
      settle_block();
      set_debounce(p == 3 ? deb_t'($urandom_range(1, 8)) : deb_t'(p + 1));
      gaps_on = (p != 4);
      run_random(85);
    end

    // no idling from here on
    gaps_on = 1'b0;
    settle_block();
    set_debounce(16'hFFFF);
    // long hold count, cut short by a smaller limit below
    repeat (2) send_sample(COLS_IDLE);
    repeat (12) send_sample(pad_sample(16'h0020, sb.next_drive));
    settle_block();
    set_debounce(16'd1);
    run_random(40);

    settle_block();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending_scans.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
